@@ src/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Used by the controller, datapath and top level; no dependencies.
package tcw_pkg;

	localparam int SCREEN_WIDTH_DEF  = 80;
	localparam int SCREEN_HEIGHT_DEF = 25;

	localparam logic [7:0]  NEWLINE_CODE = 8'd10;
	localparam logic [7:0]  DEL_CODE     = 8'h7F;
	localparam logic [7:0]  BLOCK_CODE   = 8'd219;
	localparam logic [15:0] BLANK_CELL   = 16'h0720;
	localparam logic [15:0] CLEARED_CELL = 16'h0020;

	localparam logic [1:0] REG_TEXT_COLOR  = 2'd0;
	localparam logic [1:0] REG_BACKGROUND  = 2'd1;
	localparam logic [1:0] REG_SCROLL_EN   = 2'd2;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic exec;
		logic capture;
		logic sweep_start;
		logic sweep_step;
		logic drain;
		logic load_out;
	} tcw_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_read;
		logic need_check;
		logic scroll_need;
		logic sweep_last;
		logic out_free;
	} tcw_stat_t;

endpackage

@@ src/tcw_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/tcw_ctrl.sv @@
// Controller state machine for the text console writer.
// Depends on tcw_pkg for the command and status structs.
module tcw_ctrl import tcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tcw_stat_t stat,
	output tcw_cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_EXEC   = 8'b0000_0100,
		ST_RDWAIT = 8'b0000_1000,
		ST_CHECK  = 8'b0001_0000,
		ST_SWEEP  = 8'b0010_0000,
		ST_DRAIN  = 8'b0100_0000,
		ST_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.is_read)         state_d = ST_RDWAIT;
				else if (stat.need_check) state_d = ST_CHECK;
				else                      state_d = ST_FINISH;
			end
			ST_RDWAIT: begin
				cmd.capture = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_CHECK: begin
				if (stat.scroll_need) begin
					cmd.sweep_start = 1'b1;
					state_d         = ST_SWEEP;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				cmd.drain = 1'b1;
				state_d   = ST_CHECK;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/tcw_datapath.sv @@
// Datapath: cursor, attribute registers, screen RAM, scroll sweep and result register.
// Depends on tcw_pkg and tcw_ram.
module tcw_datapath import tcw_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tcw_cmd_t    cmd,
	output tcw_stat_t   stat,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        operation,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] cell_value,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_column
);

	localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(SCREEN_HEIGHT + 1);
	localparam int CW    = $clog2(SCREEN_WIDTH);

	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [7:0]    tc_q;
	logic [3:0]    bg_q;
	logic          scroll_en_q;
	logic          op_q;
	logic [7:0]    char_q;
	logic [AW-1:0] addr_q;
	logic          in_range_q;
	logic [15:0]   val_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] last_q;
	logic [AW-1:0] copy_end_q;
	logic [AW-1:0] wa_s1;
	logic          wcopy_s1;
	logic          wv_s1;
	logic          out_valid_q;
	logic [15:0]   out_value_q;
	logic [4:0]    out_row_q;
	logic [6:0]    out_col_q;

	logic [7:0]    attr_new;
	logic [7:0]    code;
	logic          is_nl;
	logic          row_on;
	logic          col_at_end;
	logic [RW-1:0] row_inc;
	logic [AW-1:0] cur_addr;
	logic [AW:0]   row_prod;
	logic [AW:0]   kw;
	logic [31:0]   addr_ext;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;

	assign attr_new   = tc_q | {bg_q, 4'b0000};
	assign code       = (char_q == DEL_CODE) ? BLOCK_CODE : char_q;
	assign is_nl      = (char_q == NEWLINE_CODE);
	assign row_on     = (row_q < RW'(SCREEN_HEIGHT));
	assign col_at_end = (col_q == CW'(SCREEN_WIDTH - 1));
	assign row_inc    = row_on ? RW'(row_q + 1'b1) : row_q;
	assign cur_addr   = AW'(AW'(row_q) * AW'(SCREEN_WIDTH)) + AW'(col_q);
	assign row_prod   = (AW+1)'((AW+1)'(row_q) * (AW+1)'(SCREEN_WIDTH));
	assign kw         = (AW+1)'(k_q) + (AW+1)'(SCREEN_WIDTH);
	assign addr_ext   = 32'(cell_address);

	assign stat.clear_last  = (k_q == AW'(CELLS - 1));
	assign stat.is_read     = op_q;
	assign stat.need_check  = !op_q && (is_nl || col_at_end);
	assign stat.scroll_need = scroll_en_q && (row_q >= RW'(SCREEN_HEIGHT - 2));
	assign stat.sweep_last  = (k_q == last_q);
	assign stat.out_free    = !out_valid_q || out_ready;

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign cell_value    = out_value_q;
	assign cursor_row    = out_row_q;
	assign cursor_column = out_col_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = BLANK_CELL;
		if (cmd.clear_step) begin
			ram_we = 1'b1;
		end else if (wv_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wa_s1;
			ram_wdata = wcopy_s1 ? ram_rdata : CLEARED_CELL;
		end else if (cmd.exec && !op_q && !is_nl && row_on) begin
			ram_we    = 1'b1;
			ram_waddr = cur_addr;
			ram_wdata = {attr_new, code};
		end
		ram_raddr = cmd.sweep_step ? kw[AW-1:0] : addr_q;
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// cursor, attributes and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			tc_q        <= 8'd7;
			bg_q        <= 4'd0;
			scroll_en_q <= 1'b1;
			k_q         <= '0;
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec && !op_q) begin
				if (is_nl) begin
					row_q <= row_inc;
					col_q <= '0;
				end else begin
					tc_q <= attr_new;
					if (col_at_end) begin
						col_q <= '0;
						row_q <= row_inc;
					end else begin
						col_q <= CW'(col_q + 1'b1);
					end
				end
			end
			if (cmd.drain) begin
				row_q <= RW'(row_q - 1'b1);
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TEXT_COLOR: tc_q        <= cfg_data;
					REG_BACKGROUND: bg_q        <= cfg_data[3:0];
					REG_SCROLL_EN:  scroll_en_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.sweep_start) begin
				k_q <= '0;
			end else if (cmd.clear_step || cmd.sweep_step) begin
				k_q <= AW'(k_q + 1'b1);
			end
			wv_s1 <= cmd.sweep_step;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= operation;
			char_q     <= char_code;
			addr_q     <= addr_ext[AW-1:0];
			in_range_q <= (addr_ext < 32'(CELLS));
		end
		if (cmd.capture) begin
			val_q <= in_range_q ? ram_rdata : 16'h0000;
		end
		if (cmd.sweep_start) begin
			last_q     <= AW'(row_prod - 1'b1);
			copy_end_q <= AW'(row_prod - (AW+1)'(SCREEN_WIDTH));
		end
		if (cmd.sweep_step) begin
			wa_s1    <= k_q;
			wcopy_s1 <= (k_q < copy_end_q);
		end
		if (cmd.load_out) begin
			out_value_q <= op_q ? val_q : 16'h0000;
			out_row_q   <= 5'(row_q);
			out_col_q   <= 7'(col_q);
		end
	end

endmodule

@@ src/text_console_writer_core.sv @@
// Text console writer: character-cell screen with cursor, attributes and scrolling.
// A plain character passes through the EXEC and FINISH states after accept; a read adds RDWAIT,
// and a newline or a wrapping character adds CHECK; each scroll pass adds a one-cell-at-a-time
// RAM copy sweep (SWEEP) and a DRAIN. One item at a time; FINISH holds until the output is free.
// Reset: asynchronous; then the screen RAM is filled cell by cell with light-grey spaces,
// with in_ready low. Depends on tcw_pkg, tcw_ctrl, tcw_datapath.
module text_console_writer_core import tcw_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] cell_value,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_column
);

	tcw_cmd_t  cmd;
	tcw_stat_t stat;

	tcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	tcw_datapath #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.char_code    (char_code),
		.cell_address (cell_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cell_value   (cell_value),
		.cursor_row   (cursor_row),
		.cursor_column(cursor_column)
	);

endmodule

@@ bench/text_console_writer_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for text_console_writer_core: directed table, then random phases.
// Keeps its own console screen, cursor and attribute model; depends on tcw_pkg and text_console_writer_core.
module text_console_writer_core_test;
	import tcw_pkg::*;

	localparam int W           = SCREEN_WIDTH_DEF;
	localparam int H           = SCREEN_HEIGHT_DEF;
	localparam int CELLS       = W * H;
	localparam int QUIET_LIMIT = 20000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 185;
	localparam int PLAN_ROWS   = 29;

	localparam logic       OP_WRITE = 1'b0;
	localparam logic       OP_READ  = 1'b1;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef enum logic {ROW_ITEM, ROW_CFG} plan_kind_t;

	typedef struct packed {
		logic [15:0] data;
		logic [4:0]  row;
		logic [6:0]  col;
	} console_result_t;

	typedef struct packed {
		plan_kind_t      kind;
		logic            op;
		logic [7:0]      code;
		logic [10:0]     addr;
		logic [7:0]      reps;
		logic [1:0]      reg_index;
		logic [7:0]      reg_value;
		logic            typed;
		console_result_t want;
	} plan_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index    = '0;
	logic [7:0]  cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic        operation    = OP_WRITE;
	logic [7:0]  char_code    = '0;
	logic [10:0] cell_address = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [15:0] cell_value;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_column;

	logic [15:0]     screen_model [0:CELLS-1];
	int unsigned     row_model;
	int unsigned     col_model;
	logic [7:0]      attr_model;
	logic [3:0]      bg_model;
	logic            scroll_on;
	console_result_t awaited_results [$];
	plan_row_t       plan [0:PLAN_ROWS-1];
	int              fail_count = 0;
	int              quiet_cycles = 0;
	logic            steady = 1'b0;

	text_console_writer_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.char_code(char_code), .cell_address(cell_address),
		.out_valid(out_valid), .out_ready(out_ready), .cell_value(cell_value),
		.cursor_row(cursor_row), .cursor_column(cursor_column)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 70)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else if (r < 99)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void next_line();
		int unsigned i;
		col_model = 0;
		if (row_model < H)
			row_model++;
		while (scroll_on && row_model >= H - 2) begin
			for (i = 0; i < (row_model - 1) * W; i++)
				screen_model[i] = screen_model[i + W];
			for (i = 0; i < W; i++)
				screen_model[(row_model - 1) * W + i] = CLEARED_CELL;
			row_model--;
		end
	endfunction

	function automatic console_result_t apply_console_item(logic op, logic [7:0] code,
			logic [10:0] addr);
		console_result_t res;
		logic [7:0]      glyph;
		res = '0;
		if (op == OP_READ) begin
			if (addr < CELLS)
				res.data = screen_model[addr];
		end else if (code == NEWLINE_CODE) begin
			next_line();
		end else begin
			glyph = (code == DEL_CODE) ? BLOCK_CODE : code;
			attr_model = attr_model | {bg_model, 4'h0};
			if (row_model < H && col_model < W)
				screen_model[row_model * W + col_model] = {attr_model, glyph};
			col_model++;
			if (col_model >= W)
				next_line();
		end
		res.row = row_model[4:0];
		res.col = col_model[6:0];
		return res;
	endfunction

	task automatic send_item(input logic op, input logic [7:0] code, input logic [10:0] addr,
			input logic typed, input console_result_t want);
		int              gap;
		console_result_t res;
		gap = idle_span();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		char_code    <= code;
		cell_address <= addr;
		do @(posedge clk); while (!in_ready);
		res = apply_console_item(op, code, addr);
		awaited_results.push_back(typed ? want : res);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_TEXT_COLOR: attr_model = val;
			REG_BACKGROUND: bg_model   = val[3:0];
			REG_SCROLL_EN:  scroll_on  = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold off until every result has come back and the core has gone quiet
	task automatic wait_console_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic report_field(input string field, input int want, input int got);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
	endtask

	always @(negedge clk) begin : result_stall
		int stall_left;
		if (stall_left > 0 && !steady) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready  <= 1'b1;
			stall_left = idle_span();
		end
	end

	always @(posedge clk) begin
		console_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 40)
					$display("%0t: unexpected item: expected none, actual cell 0x%0h row %0d col %0d",
						$time, cell_value, cursor_row, cursor_column);
			end else begin
				want = awaited_results.pop_front();
				if (cell_value !== want.data)
					report_field("cell_value", want.data, cell_value);
				if (cursor_row !== want.row)
					report_field("cursor_row", want.row, cursor_row);
				if (cursor_column !== want.col)
					report_field("cursor_column", want.col, cursor_column);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned     k, p, n, r, spot;
		logic [7:0]      val;
		console_result_t none;

		none = '0;
		for (k = 0; k < CELLS; k++)
			screen_model[k] = BLANK_CELL;
		row_model  = 0;
		col_model  = 0;
		attr_model = 8'd7;
		bg_model   = 4'd0;
		scroll_on  = 1'b1;

		plan = '{
			'{ROW_ITEM, OP_READ,  8'h00,        11'd0,    8'd1,  '0, '0, 1'b1, '{16'h0720, 5'd0, 7'd0}},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd1999, 8'd1,  '0, '0, 1'b1, '{16'h0720, 5'd0, 7'd0}},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd2047, 8'd1,  '0, '0, 1'b1, '{16'h0000, 5'd0, 7'd0}},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd2000, 8'd1,  '0, '0, 1'b1, '{16'h0000, 5'd0, 7'd0}},
			'{ROW_ITEM, OP_WRITE, 8'h41,        11'd0,    8'd1,  '0, '0, 1'b1, '{16'h0000, 5'd0, 7'd1}},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd0,    8'd1,  '0, '0, 1'b1, '{16'h0741, 5'd0, 7'd1}},
			'{ROW_ITEM, OP_WRITE, DEL_CODE,     11'd0,    8'd1,  '0, '0, 1'b1, '{16'h0000, 5'd0, 7'd2}},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd1,    8'd1,  '0, '0, 1'b1, '{16'h07DB, 5'd0, 7'd2}},
			'{ROW_ITEM, OP_WRITE, 8'h00,        11'd0,    8'd1,  '0, '0, 1'b1, '{16'h0000, 5'd0, 7'd3}},
			'{ROW_ITEM, OP_WRITE, 8'hFF,        11'h7FF,  8'd1,  '0, '0, 1'b1, '{16'h0000, 5'd0, 7'd4}},
			'{ROW_ITEM, OP_WRITE, NEWLINE_CODE, 11'd0,    8'd1,  '0, '0, 1'b1, '{16'h0000, 5'd1, 7'd0}},
			'{ROW_CFG,  OP_WRITE, 8'h00, 11'd0, 8'd0, REG_BACKGROUND, 8'h0F, 1'b0, '0},
			'{ROW_CFG,  OP_WRITE, 8'h00, 11'd0, 8'd0, REG_NONE,       8'hFF, 1'b0, '0},
			'{ROW_ITEM, OP_WRITE, 8'h42,        11'd0,    8'd1,  '0, '0, 1'b0, '0},
			'{ROW_CFG,  OP_WRITE, 8'h00, 11'd0, 8'd0, REG_TEXT_COLOR, 8'h00, 1'b0, '0},
			'{ROW_ITEM, OP_WRITE, 8'h43,        11'd0,    8'd1,  '0, '0, 1'b0, '0},
			'{ROW_CFG,  OP_WRITE, 8'h00, 11'd0, 8'd0, REG_BACKGROUND, 8'h00, 1'b0, '0},
			'{ROW_CFG,  OP_WRITE, 8'h00, 11'd0, 8'd0, REG_TEXT_COLOR, 8'hFF, 1'b0, '0},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd80,   8'd1,  '0, '0, 1'b0, '0},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd81,   8'd1,  '0, '0, 1'b0, '0},
			'{ROW_CFG,  OP_WRITE, 8'h00, 11'd0, 8'd0, REG_SCROLL_EN,  8'h00, 1'b0, '0},
			'{ROW_ITEM, OP_WRITE, NEWLINE_CODE, 11'd0,    8'd26, '0, '0, 1'b0, '0},
			'{ROW_ITEM, OP_WRITE, 8'h58,        11'd0,    8'd1,  '0, '0, 1'b0, '0},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd1999, 8'd1,  '0, '0, 1'b0, '0},
			'{ROW_CFG,  OP_WRITE, 8'h00, 11'd0, 8'd0, REG_SCROLL_EN,  8'h01, 1'b0, '0},
			'{ROW_ITEM, OP_WRITE, NEWLINE_CODE, 11'd0,    8'd1,  '0, '0, 1'b0, '0},
			'{ROW_ITEM, OP_WRITE, 8'h5A,        11'd0,    8'd80, '0, '0, 1'b0, '0},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd0,    8'd1,  '0, '0, 1'b0, '0},
			'{ROW_ITEM, OP_READ,  8'h00,        11'd1760, 8'd1,  '0, '0, 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < PLAN_ROWS; k++) begin
			if (plan[k].kind == ROW_CFG) begin
				wait_console_idle();
				write_register(plan[k].reg_index, plan[k].reg_value);
			end else begin
				repeat (plan[k].reps)
					send_item(plan[k].op, plan[k].code, plan[k].addr, plan[k].typed, plan[k].want);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			wait_console_idle();
			steady = (p == 3);
			val = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255));
			write_register(REG_TEXT_COLOR, val);
			val = (p % 3 == 0) ? 8'h00 : (p % 3 == 1) ? 8'h0F : 8'($urandom_range(0, 255));
			write_register(REG_BACKGROUND, val);
			write_register(REG_SCROLL_EN, (p == 2 || p == 5) ? 8'h00 : 8'h01);
			if (p % 2 == 1)
				write_register(REG_NONE, 8'($urandom_range(0, 255)));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 6 && n == PHASE_ITEMS / 2)
					wait_console_idle();
				r = $urandom_range(0, 99);
				if (r < 12) begin
					// drop into the row under the cursor to see fresh writes
					spot = row_model * W + $urandom_range(0, W - 1);
					if (spot > 2047)
						spot = 2047;
					send_item(OP_READ, 8'($urandom_range(0, 255)), 11'(spot), 1'b0, none);
				end else if (r < 36) begin
					send_item(OP_READ, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, CELLS - 1)), 1'b0, none);
				end else if (r < 40) begin
					send_item(OP_READ, 8'($urandom_range(0, 255)),
						11'($urandom_range(CELLS, 2047)), 1'b0, none);
				end else if (r < 45) begin
					send_item(OP_WRITE, NEWLINE_CODE, 11'($urandom_range(0, 2047)), 1'b0, none);
				end else if (r < 48) begin
					send_item(OP_WRITE, DEL_CODE, 11'($urandom_range(0, 2047)), 1'b0, none);
				end else begin
					send_item(OP_WRITE, 8'($urandom_range(0, 255)),
						11'($urandom_range(0, 2047)), 1'b0, none);
				end
			end
		end

		steady = 1'b0;
		wait_console_idle();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
